// File: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// shared types and codes for the shadow call stack tracker
// ----------------------------------------------------------------------------
package sct_pkg;

	// event codes reported per instruction
	localparam logic [3:0] EV_REPEAT   = 4'd0;
	localparam logic [3:0] EV_ZERO_PC  = 4'd1;
	localparam logic [3:0] EV_PLAIN    = 4'd2;
	localparam logic [3:0] EV_CALL     = 4'd3;
	localparam logic [3:0] EV_RETURN   = 4'd4;
	localparam logic [3:0] EV_IRQ      = 4'd5;
	localparam logic [3:0] EV_IRQ_RET  = 4'd6;
	localparam logic [3:0] EV_SWITCH   = 4'd7;
	localparam logic [3:0] EV_BR_IGN   = 4'd8;
	localparam logic [3:0] EV_UNKNOWN  = 4'd9;

	localparam logic [7:0]  IRQ_SELECT   = 8'd128;
	localparam logic [31:0] VECTOR_RESET = 32'h0000_0018;
	localparam logic [31:0] NO_PC        = 32'hFFFF_FFFF;
	localparam logic [7:0]  NEST_MAX     = 8'hFF;
	localparam logic [31:0] JUMP_MIN     = 32'd16;

	// exit instruction patterns
	localparam logic [31:0] T32_POP_SWITCH = 32'hc000_e9bd;
	localparam logic [31:0] T16_BCC_MASK   = 32'h0000_F000;
	localparam logic [31:0] T16_BCC_VAL    = 32'h0000_D000;
	localparam logic [31:0] A32_B_MASK     = 32'h0F00_0000;
	localparam logic [31:0] A32_B_VAL      = 32'h0A00_0000;
	localparam logic [31:0] A32_SWITCH_A   = 32'he8fd_dfff;
	localparam logic [31:0] A32_SWITCH_B   = 32'he8d4_ffff;
	localparam logic [31:0] A32_RETI_A     = 32'he8fd_901f;
	localparam logic [31:0] A32_RETI_B     = 32'he8fd_800f;

	typedef enum logic [1:0] {
		ACT_UNKNOWN = 2'd0,
		ACT_IGNORE  = 2'd1,
		ACT_SWITCH  = 2'd2,
		ACT_RETI    = 2'd3
	} act_t;

	// one shadow stack frame
	typedef struct packed {
		logic        irq;
		logic [31:0] link;
		logic [31:0] sp;
	} frame_t;

	// one result
	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  sel;
		logic [7:0]  depth;
		logic [7:0]  nest;
		logic [31:0] fra;
		logic        mism;
		logic        fault;
	} res_t;

endpackage

// File: rtl/sct_frame_mem.sv
// ----------------------------------------------------------------------------
// sct_frame_mem
// frame store for all shadow stacks, one port, registered read
// ----------------------------------------------------------------------------
module sct_frame_mem #(
	parameter int DEPTH = 16512,
	parameter int AW    = 15
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        addr,
	input  sct_pkg::frame_t      wdata,
	output sct_pkg::frame_t      rdata
);

	sct_pkg::frame_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/sct_depth_mem.sv
// ----------------------------------------------------------------------------
// sct_depth_mem
// per-task stack depth store, valid bit per entry so reset reads as zero
// ----------------------------------------------------------------------------
module sct_depth_mem #(
	parameter int ENTRIES = 128,
	parameter int AW      = 7,
	parameter int DW      = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0]      mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [DW-1:0]      rd_q;
	logic               rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
			rv_q <= valid_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	// never written reads as an empty stack
	assign rdata = rv_q ? rd_q : '0;

endmodule

// File: rtl/shadow_call_stack_tracker.sv
// ----------------------------------------------------------------------------
// shadow_call_stack_tracker
// shadow call stacks per task plus an interrupt stack, fed by retired
// instructions
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries one retired instruction per
//   request; output channel out_valid/out_ready returns one result per request
// - cfg_we/cfg_wdata writes the interrupt vector address; the user must do so
//   only while idle, as the block does not enforce it
// - most instructions pass the steps accept, depth memory read, decide and
//   result register in that order
// - a return candidate walks its stack top down, one frame memory read and
//   check per frame (frame memory port); an interrupt return walks the
//   interrupt stack the same way
// - one item in flight; in_ready is high only while the sequencer is idle
// - a finished result waits in the output register; the next request is
//   accepted meanwhile and held in the emit step until the register frees
// - reset clears the depths (valid bits), nesting and history registers;
//   frame contents are undefined until pushed and never read before that
// ----------------------------------------------------------------------------
module shadow_call_stack_tracker #(
	parameter int TASK_STACKS = 128,
	parameter int STACK_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] program_counter,
	input  logic [31:0] link_register,
	input  logic [31:0] stack_pointer,
	input  logic [2:0]  instruction_size,
	input  logic [31:0] instruction_word,
	input  logic [6:0]  task_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [7:0]  stack_select,
	output logic [7:0]  depth_after,
	output logic [7:0]  nest_level,
	output logic [31:0] frame_return_address,
	output logic        sp_mismatch,
	output logic        fault
);

	localparam int NSTK  = TASK_STACKS + 1;
	localparam int SW    = $clog2(NSTK);
	localparam int TW    = (TASK_STACKS > 1) ? $clog2(TASK_STACKS) : 1;
	localparam int DW    = $clog2(STACK_DEPTH + 1);
	localparam int KW    = $clog2(STACK_DEPTH);
	localparam int FDEP  = NSTK * STACK_DEPTH;
	localparam int AW    = $clog2(FDEP);
	localparam int RECIP = (1 << 24) / TASK_STACKS + 1;
	localparam logic [SW-1:0] ISTK = SW'(TASK_STACKS);
	localparam logic [DW-1:0] DFULL = DW'(STACK_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDEP = 8'b0000_0010,
		S_DEC  = 8'b0000_0100,
		S_RRD  = 8'b0000_1000,
		S_RCHK = 8'b0001_0000,
		S_IRD  = 8'b0010_0000,
		S_ICHK = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// request registers
	logic [31:0]   pc_q, lr_q, sp_q, word_q;
	logic [2:0]    size_q;
	logic [SW-1:0] tsid_q;

	// history and tracker state
	logic [31:0]   last_pc_q, last_lr_q, last_sp_q, last_word_q, vec_q;
	logic [2:0]    last_size_q;
	logic [7:0]    nest_q, nest_d;
	logic [DW-1:0] idep_q, idep_d;
	logic [DW-1:0] cdep_q, cdep_d;
	logic [KW-1:0] k_q, k_d;

	sct_pkg::res_t res_q, res_d, out_q;
	logic          out_valid_q;
	logic          upd;

	// task number mod stack count by reciprocal multiply
	logic [31:0] tprod, trem;
	logic [7:0]  tquo;
	assign tprod = 32'(task_number) * 32'(RECIP);
	assign tquo  = tprod[31:24];
	assign trem  = 32'(task_number) - 32'(tquo) * 32'(TASK_STACKS);

	// memories
	logic            fm_we;
	logic [AW-1:0]   fm_addr;
	sct_pkg::frame_t fm_wdata, fm_rdata;
	logic            dm_we;
	logic [DW-1:0]   dm_wdata, dm_rdata;

	sct_frame_mem #(.DEPTH(FDEP), .AW(AW)) u_frame (
		.clk   (clk),
		.we    (fm_we),
		.addr  (fm_addr),
		.wdata (fm_wdata),
		.rdata (fm_rdata)
	);

	sct_depth_mem #(.ENTRIES(TASK_STACKS), .AW(TW), .DW(DW)) u_depth (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dm_we),
		.addr   (tsid_q[TW-1:0]),
		.wdata  (dm_wdata),
		.rdata  (dm_rdata)
	);

	// instruction classification
	logic [31:0] pc0, ppc0, jd, jmag, fa_push, fa_rd, fa_irq, ssum;
	logic        in_irq, rep, zpc, vec_hit, pvec, ret_cond, call_cond, big;
	logic [SW-1:0] cur_sid;
	logic [DW-1:0] cdep;
	sct_pkg::act_t act;

	assign pc0     = {pc_q[31:1], 1'b0};
	assign ppc0    = {last_pc_q[31:1], 1'b0};
	assign in_irq  = (nest_q != 8'd0);
	assign cur_sid = in_irq ? ISTK : tsid_q;
	assign cdep    = (state_q == S_DEC) ? (in_irq ? idep_q : dm_rdata) : cdep_q;
	assign rep     = (ppc0 == pc0) && (last_sp_q == sp_q) && (last_lr_q == lr_q);
	assign zpc     = (pc0 == 32'd0);
	assign vec_hit = (pc0 == vec_q);
	assign pvec    = (ppc0 == vec_q);
	assign ret_cond = (pc_q != last_pc_q + 32'd4) && (pc_q != last_pc_q + 32'd2)
		&& ((pc_q == lr_q) || (sp_q != last_sp_q));
	assign ssum      = 32'(last_size_q);
	assign call_cond = ({lr_q[31:1], 1'b0} == ppc0 + ssum) && (pc_q != last_pc_q + ssum);
	assign jd   = pc_q - last_pc_q;
	assign jmag = jd[31] ? (32'd0 - jd) : jd;
	assign big  = (jmag > sct_pkg::JUMP_MIN) && (last_pc_q != sct_pkg::NO_PC);

	// frame addresses: stack base plus index
	assign fa_push = 32'(cur_sid) * 32'(STACK_DEPTH) + 32'(cdep[KW-1:0]);
	assign fa_rd   = 32'(cur_sid) * 32'(STACK_DEPTH) + 32'(k_q);
	assign fa_irq  = 32'(ISTK) * 32'(STACK_DEPTH) + 32'(in_irq ? idep_q[KW-1:0] : '0);

	always_comb begin
		act = sct_pkg::ACT_UNKNOWN;
		if (last_pc_q[0]) begin
			if (last_size_q == 3'd4) begin
				if (last_word_q == sct_pkg::T32_POP_SWITCH) act = sct_pkg::ACT_SWITCH;
			end else if (last_size_q == 3'd2) begin
				if ((last_word_q & sct_pkg::T16_BCC_MASK) == sct_pkg::T16_BCC_VAL)
					act = sct_pkg::ACT_IGNORE;
			end
		end else begin
			if ((last_word_q & sct_pkg::A32_B_MASK) == sct_pkg::A32_B_VAL)
				act = sct_pkg::ACT_IGNORE;
			else if (last_word_q == sct_pkg::A32_SWITCH_A || last_word_q == sct_pkg::A32_SWITCH_B)
				act = sct_pkg::ACT_SWITCH;
			else if (last_word_q == sct_pkg::A32_RETI_A || last_word_q == sct_pkg::A32_RETI_B)
				act = sct_pkg::ACT_RETI;
		end
	end

	// tail of the decision: call push, plain step or jump classification
	sct_pkg::res_t t_res;
	logic          t_upd, t_push, t_irq_walk, t_irq_none;

	always_comb begin
		t_res      = '{kind: sct_pkg::EV_PLAIN,
			sel: (cur_sid == ISTK) ? sct_pkg::IRQ_SELECT : 8'(cur_sid),
			depth: 8'(cdep), nest: nest_q, fra: 32'd0, mism: 1'b0, fault: 1'b0};
		t_upd      = 1'b1;
		t_push     = 1'b0;
		t_irq_walk = 1'b0;
		t_irq_none = 1'b0;
		if (call_cond) begin
			t_res.kind = sct_pkg::EV_CALL;
			t_res.fra  = lr_q;
			if (cdep >= DFULL) begin
				t_res.fault = 1'b1;
				t_upd       = 1'b0;
			end else begin
				t_push      = 1'b1;
				t_res.depth = 8'(cdep + DW'(1));
			end
		end else if (big) begin
			unique case (act)
				sct_pkg::ACT_IGNORE:  t_res.kind = sct_pkg::EV_BR_IGN;
				sct_pkg::ACT_UNKNOWN: t_res.kind = sct_pkg::EV_UNKNOWN;
				sct_pkg::ACT_SWITCH, sct_pkg::ACT_RETI: begin
					if (!in_irq) begin
						if (act == sct_pkg::ACT_SWITCH) begin
							t_res.kind = sct_pkg::EV_SWITCH;
						end else begin
							t_res.kind  = sct_pkg::EV_IRQ_RET;
							t_res.fault = 1'b1;
							t_upd       = 1'b0;
						end
					end else if (idep_q == '0) begin
						// nothing to unwind: drop to task level
						t_irq_none = 1'b1;
						t_res      = '{kind: sct_pkg::EV_SWITCH, sel: sct_pkg::IRQ_SELECT,
							depth: 8'd0, nest: 8'd0, fra: 32'd0, mism: 1'b0, fault: 1'b0};
					end else begin
						t_irq_walk = 1'b1;
						t_upd      = 1'b0;
					end
				end
				default: t_res.kind = sct_pkg::EV_UNKNOWN;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		nest_d   = nest_q;
		idep_d   = idep_q;
		cdep_d   = cdep_q;
		k_d      = k_q;
		upd      = 1'b0;
		fm_we    = 1'b0;
		fm_addr  = fa_rd[AW-1:0];
		fm_wdata = '{irq: 1'b0, link: lr_q, sp: sp_q};
		dm_we    = 1'b0;
		dm_wdata = cdep + DW'(1);

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_RDEP;
			end
			S_RDEP: state_d = S_DEC;
			S_DEC: begin
				cdep_d  = cdep;
				state_d = S_EMIT;
				res_d   = '{kind: sct_pkg::EV_PLAIN,
					sel: (cur_sid == ISTK) ? sct_pkg::IRQ_SELECT : 8'(cur_sid),
					depth: 8'(cdep), nest: nest_q, fra: 32'd0, mism: 1'b0, fault: 1'b0};
				priority if (rep) begin
					res_d.kind = sct_pkg::EV_REPEAT;
				end else if (zpc) begin
					res_d.kind = sct_pkg::EV_ZERO_PC;
				end else if (vec_hit) begin
					res_d.kind = sct_pkg::EV_IRQ;
					res_d.sel  = sct_pkg::IRQ_SELECT;
					res_d.fra  = last_pc_q;
					if (nest_q == sct_pkg::NEST_MAX || (in_irq && idep_q >= DFULL)) begin
						res_d.depth = 8'(idep_q);
						res_d.fault = 1'b1;
					end else begin
						// first entry starts from an empty interrupt stack
						fm_we    = 1'b1;
						fm_addr  = fa_irq[AW-1:0];
						fm_wdata = '{irq: 1'b1, link: last_pc_q, sp: sp_q};
						idep_d   = (in_irq ? idep_q : '0) + DW'(1);
						nest_d   = nest_q + 8'd1;
						res_d.depth = 8'((in_irq ? idep_q : '0) + DW'(1));
						res_d.nest  = nest_q + 8'd1;
						upd = 1'b1;
					end
				end else if (pvec) begin
					res_d.kind = sct_pkg::EV_BR_IGN;
					upd = 1'b1;
				end else if (ret_cond && cdep != '0) begin
					k_d     = KW'(cdep - DW'(1));
					state_d = S_RRD;
				end else begin
					res_d = t_res;
					upd   = t_upd;
					if (t_push) begin
						fm_we   = 1'b1;
						fm_addr = fa_push[AW-1:0];
						if (in_irq) idep_d = cdep + DW'(1);
						else dm_we = 1'b1;
					end
					if (t_irq_none) begin
						idep_d = '0;
						nest_d = 8'd0;
					end
					if (t_irq_walk) begin
						k_d     = KW'(idep_q - DW'(1));
						state_d = S_IRD;
					end
				end
			end
			S_RRD: state_d = S_RCHK;
			S_RCHK: begin
				if (!fm_rdata.irq && fm_rdata.link == pc_q) begin
					// matched return: cut the stack back to this frame
					res_d = '{kind: sct_pkg::EV_RETURN,
						sel: (cur_sid == ISTK) ? sct_pkg::IRQ_SELECT : 8'(cur_sid),
						depth: 8'(k_q), nest: nest_q, fra: pc_q,
						mism: (sp_q != fm_rdata.sp), fault: 1'b0};
					dm_wdata = DW'(k_q);
					if (in_irq) idep_d = DW'(k_q);
					else dm_we = 1'b1;
					upd     = 1'b1;
					state_d = S_EMIT;
				end else if (k_q != '0) begin
					k_d     = k_q - KW'(1);
					state_d = S_RRD;
				end else begin
					res_d   = t_res;
					upd     = t_upd;
					state_d = S_EMIT;
					if (t_push) begin
						fm_we   = 1'b1;
						fm_addr = fa_push[AW-1:0];
						if (in_irq) idep_d = cdep + DW'(1);
						else dm_we = 1'b1;
					end
					if (t_irq_none) begin
						idep_d = '0;
						nest_d = 8'd0;
					end
					if (t_irq_walk) begin
						k_d     = KW'(idep_q - DW'(1));
						state_d = S_IRD;
					end
				end
			end
			S_IRD: state_d = S_ICHK;
			S_ICHK: begin
				if (fm_rdata.irq) begin
					// each interrupt frame passed unwinds one level
					nest_d = (nest_q != 8'd0) ? nest_q - 8'd1 : nest_q;
					idep_d = DW'(k_q);
				end
				if (fm_rdata.irq &&
					(pc_q == fm_rdata.link || pc_q == fm_rdata.link + 32'd4)) begin
					res_d = '{kind: sct_pkg::EV_IRQ_RET, sel: sct_pkg::IRQ_SELECT,
						depth: 8'(k_q), nest: (nest_q != 8'd0) ? nest_q - 8'd1 : nest_q,
						fra: fm_rdata.link, mism: 1'b0, fault: 1'b0};
					upd     = 1'b1;
					state_d = S_EMIT;
				end else if (k_q != '0) begin
					k_d     = k_q - KW'(1);
					state_d = S_IRD;
				end else begin
					// no matching frame: everything dropped
					idep_d  = '0;
					nest_d  = 8'd0;
					res_d   = '{kind: sct_pkg::EV_SWITCH, sel: sct_pkg::IRQ_SELECT,
						depth: 8'd0, nest: 8'd0, fra: 32'd0, mism: 1'b0, fault: 1'b0};
					upd     = 1'b1;
					state_d = S_EMIT;
				end
				fm_addr = fa_rd[AW-1:0];
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		// walks over the interrupt stack read there
		if (state_q == S_IRD) begin
			fm_addr = AW'(32'(ISTK) * 32'(STACK_DEPTH) + 32'(k_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nest_q      <= 8'd0;
			idep_q      <= '0;
			last_pc_q   <= sct_pkg::NO_PC;
			last_lr_q   <= 32'd0;
			last_sp_q   <= 32'd0;
			last_size_q <= 3'd0;
			last_word_q <= 32'd0;
			vec_q       <= sct_pkg::VECTOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nest_q  <= nest_d;
			idep_q  <= idep_d;
			if (cfg_we) vec_q <= cfg_wdata;
			if (upd) begin
				last_pc_q   <= pc_q;
				last_lr_q   <= lr_q;
				last_sp_q   <= sp_q;
				last_size_q <= size_q;
				last_word_q <= word_q;
			end
			if (state_q == S_EMIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			pc_q   <= program_counter;
			lr_q   <= link_register;
			sp_q   <= stack_pointer;
			size_q <= instruction_size;
			word_q <= instruction_word;
			tsid_q <= trem[SW-1:0];
		end
		res_q  <= res_d;
		cdep_q <= cdep_d;
		k_q    <= k_d;
		if (state_q == S_EMIT && (!out_valid_q || out_ready)) out_q <= res_q;
	end

	assign in_ready             = (state_q == S_IDLE);
	assign out_valid            = out_valid_q;
	assign event_kind           = out_q.kind;
	assign stack_select         = out_q.sel;
	assign depth_after          = out_q.depth;
	assign nest_level           = out_q.nest;
	assign frame_return_address = out_q.fra;
	assign sp_mismatch          = out_q.mism;
	assign fault                = out_q.fault;

endmodule

// File: rtl/sct_checker.sv
// ----------------------------------------------------------------------------
// sct_checker
// port-level checks for the shadow call stack tracker
// ----------------------------------------------------------------------------
module sct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] event_kind,
	input logic [7:0] stack_select,
	input logic       sp_mismatch,
	input logic       fault
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(event_kind) && $stable(fault)))
		else $error("stalled result changed");

	// faults only on call, interrupt entry or interrupt return
	a_fault_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault) |-> (event_kind == sct_pkg::EV_CALL
			|| event_kind == sct_pkg::EV_IRQ || event_kind == sct_pkg::EV_IRQ_RET))
		else $error("fault on wrong event");

	// mismatch only on a return
	a_mism_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sp_mismatch) |-> (event_kind == sct_pkg::EV_RETURN))
		else $error("sp mismatch outside a return");

	// interrupt entry always touches the interrupt stack
	a_irq_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == sct_pkg::EV_IRQ) |-> (stack_select == sct_pkg::IRQ_SELECT))
		else $error("interrupt entry on a task stack");

endmodule

bind shadow_call_stack_tracker sct_checker u_sct_checker (.*);
